/* rtl/tstt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task state transition tracker package
// Shared state codes, status codes, the legality matrix and the record types
// passed between the front end and the back end.
// ----------------------------------------------------------------------------
package tstt_pkg;

    // Task state codes.
    localparam logic [2:0] TS_INVALID    = 3'd0;
    localparam logic [2:0] TS_READY      = 3'd1;
    localparam logic [2:0] TS_RUNNING    = 3'd2;
    localparam logic [2:0] TS_BLOCKED    = 3'd3;
    localparam logic [2:0] TS_SUSPENDED  = 3'd4;
    localparam logic [2:0] TS_TERMINATED = 3'd5;
    localparam logic [2:0] TS_DORMANT    = 3'd6;

    // Highest state code that a request may name.
    localparam logic [2:0] TS_MAX = TS_DORMANT;

    // Result status of one request.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_ILLEGAL = 2'd2
    } t_status;

    // Allowed targets per source state, one bit per target state.
    localparam logic [7:0] LEGAL_TARGETS [8] = '{
        8'h42,  // invalid: ready, dormant
        8'h3C,  // ready: running, blocked, suspended, terminated
        8'h3A,  // running: ready, blocked, suspended, terminated
        8'h32,  // blocked: ready, suspended, terminated
        8'h22,  // suspended: ready, terminated
        8'h00,  // terminated: no exits
        8'h22,  // dormant: ready, terminated
        8'h00
    };

    // Classified request as it sits in the queue.
    typedef struct packed {
        logic [63:0] time_now;
        logic [2:0]  target;
        logic        range_err;
    } t_cmd_info;

    // Per-task table entry.
    typedef struct packed {
        logic [2:0]  state;
        logic [2:0]  last_state;
        logic [63:0] run_start;
        logic [63:0] last_len;
        logic [63:0] run_total;
        logic [31:0] switches;
        logic [31:0] wake_lat;
    } t_task_rec;

    // Back-end sequencer states.
    typedef enum logic {
        BK_FETCH,
        BK_EXEC
    } t_back_state;

endpackage
`default_nettype wire

/* rtl/task_state_transition_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task state transition tracker
// Per-task state machine bookkeeping with legality checking, run-time
// accounting, wake latency capture and a transition history ring.
// ----------------------------------------------------------------------------
// Each input transaction asks to move one task to a target state at the given
// time; each one yields exactly one result transaction carrying the status,
// the prior state and the task's updated statistics. The back end handles every
// request in two steps, BK_FETCH to read the task table memory and BK_EXEC to
// update and write the entry back, so it takes no new request before the last
// one is written back, as set by that single-port read-modify-write of the table.
// A request passes through the queue, the table read register and the result
// register. A two-entry queue sits between the front end and the back end, so
// input keeps being taken while the result register waits on the consumer.
// After reset every task reads as invalid with zero statistics at once: a
// per-task valid bit masks entries that have never been written, so there is
// no clearing pass. Task numbers at or above NUM_TASKS wrap modulo NUM_TASKS.
// ----------------------------------------------------------------------------
module task_state_transition_tracker #(
    parameter int NUM_TASKS     = 16,
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_task_number,
    input  wire logic [2:0]  i_target_state,
    input  wire logic [63:0] i_time_now,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_prior_state,
    output logic             o_state_changed,
    output logic [63:0]      o_ended_run_length,
    output logic [63:0]      o_task_run_total,
    output logic [31:0]      o_task_switches,
    output logic [31:0]      o_task_wake_latency,
    output logic [31:0]      o_transitions_total,
    output logic [31:0]      o_rejected_total,
    output logic [2:0]       o_history_slot
);

    localparam int TW = $clog2(NUM_TASKS);

    // Queue head handed from the front end to the back end.
    logic                cmd_valid;
    logic                cmd_pop;
    logic [TW-1:0]       cmd_task;
    tstt_pkg::t_cmd_info cmd_info;

    // The front end wraps the task number and flags out-of-range targets.
    tstt_front #(
        .NUM_TASKS(NUM_TASKS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_task_number (i_task_number),
        .i_target_state(i_target_state),
        .i_time_now    (i_time_now),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop),
        .o_cmd_task    (cmd_task),
        .o_cmd_info    (cmd_info)
    );

    // The back end owns the task table, the counters and the history ring.
    tstt_back #(
        .NUM_TASKS    (NUM_TASKS),
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_valid        (cmd_valid),
        .o_cmd_pop          (cmd_pop),
        .i_cmd_task         (cmd_task),
        .i_cmd_info         (cmd_info),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_prior_state      (o_prior_state),
        .o_state_changed    (o_state_changed),
        .o_ended_run_length (o_ended_run_length),
        .o_task_run_total   (o_task_run_total),
        .o_task_switches    (o_task_switches),
        .o_task_wake_latency(o_task_wake_latency),
        .o_transitions_total(o_transitions_total),
        .o_rejected_total   (o_rejected_total),
        .o_history_slot     (o_history_slot)
    );

endmodule
`default_nettype wire

/* rtl/tstt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions, wraps the task number onto the table and
// flags out-of-range targets, then holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tstt_front #(
    parameter int NUM_TASKS = 16,
    localparam int TW = $clog2(NUM_TASKS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [3:0]            i_task_number,
    input  wire logic [2:0]            i_target_state,
    input  wire logic [63:0]           i_time_now,
    output logic                       o_cmd_valid,
    input  wire logic                  i_cmd_pop,
    output logic [TW-1:0]              o_cmd_task,
    output tstt_pkg::t_cmd_info        o_cmd_info
);

    logic [TW-1:0]       r_q_task [2];
    tstt_pkg::t_cmd_info r_q_info [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_push;
    logic [4:0]          w_wrap;
    tstt_pkg::t_cmd_info w_info;

    // Task number modulo the table size, by repeated subtraction.
    always_comb begin
        w_wrap = {1'b0, i_task_number};
        for (int k = 0; k < 8; k++) begin
            if (int'(w_wrap) >= NUM_TASKS) begin
                w_wrap = w_wrap - 5'(NUM_TASKS);
            end
        end
    end

    always_comb begin
        w_info.time_now  = i_time_now;
        w_info.target    = i_target_state;
        w_info.range_err = (i_target_state > tstt_pkg::TS_MAX);
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd_task  = r_q_task[r_rd_ptr];
    assign o_cmd_info  = r_q_info[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_task[r_wr_ptr] <= TW'(w_wrap);
            r_q_info[r_wr_ptr] <= w_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/tstt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Reads the task table entry, checks legality, updates the entry, the global
// counters and the history ring, and loads the result register.
// ----------------------------------------------------------------------------
module tstt_back #(
    parameter int NUM_TASKS     = 16,
    parameter int HISTORY_DEPTH = 8,
    localparam int TW = $clog2(NUM_TASKS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    output logic                       o_cmd_pop,
    input  wire logic [TW-1:0]         i_cmd_task,
    input  wire tstt_pkg::t_cmd_info   i_cmd_info,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_status,
    output logic [2:0]                 o_prior_state,
    output logic                       o_state_changed,
    output logic [63:0]                o_ended_run_length,
    output logic [63:0]                o_task_run_total,
    output logic [31:0]                o_task_switches,
    output logic [31:0]                o_task_wake_latency,
    output logic [31:0]                o_transitions_total,
    output logic [31:0]                o_rejected_total,
    output logic [2:0]                 o_history_slot
);

    localparam int HW  = $clog2(HISTORY_DEPTH);
    localparam int HXW = (HW > 3) ? HW : 3;

    tstt_pkg::t_back_state r_state;
    tstt_pkg::t_back_state n_state;

    tstt_pkg::t_task_rec   r_mem [NUM_TASKS];
    logic [41:0]           r_hist [HISTORY_DEPTH];
    logic [NUM_TASKS-1:0]  r_live;

    tstt_pkg::t_task_rec   r_rd_rec;
    logic                  r_rd_live;
    logic [TW-1:0]         r_cur_task;
    tstt_pkg::t_cmd_info   r_cur_info;

    logic [31:0]           r_trans_cnt;
    logic [31:0]           n_trans_cnt;
    logic [31:0]           r_rej_cnt;
    logic [31:0]           n_rej_cnt;
    logic [HW-1:0]         r_hist_ptr;
    logic [HW-1:0]         n_hist_ptr;

    logic                  r_out_valid;
    tstt_pkg::t_status     r_out_status;
    logic [2:0]            r_out_prior;
    logic                  r_out_changed;
    tstt_pkg::t_task_rec   r_out_rec;
    logic [2:0]            r_out_slot;

    logic                  w_fire;
    logic                  w_pop;
    tstt_pkg::t_task_rec   w_cur;
    tstt_pkg::t_task_rec   n_rec;
    tstt_pkg::t_status     w_status;
    logic                  w_ok;
    logic [2:0]            w_from;
    logic [2:0]            w_to;
    logic [63:0]           w_len;
    logic [HXW-1:0]        w_slot_ext;

    // Sequencer: BK_FETCH for the table read, BK_EXEC for update and write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tstt_pkg::BK_FETCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_pop   = 1'b0;
        w_fire  = 1'b0;
        unique case (r_state)
            tstt_pkg::BK_FETCH: begin
                if (i_cmd_valid) begin
                    w_pop   = 1'b1;
                    n_state = tstt_pkg::BK_EXEC;
                end
            end
            tstt_pkg::BK_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_fire  = 1'b1;
                    n_state = tstt_pkg::BK_FETCH;
                end
            end
            default: begin
                n_state = tstt_pkg::BK_FETCH;
            end
        endcase
    end

    assign o_cmd_pop = w_pop;

    // Table memory with registered read; unwritten entries are masked to zero by the live bit.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_ok) begin
            r_mem[r_cur_task] <= n_rec;
        end
        if (w_pop) begin
            r_rd_rec   <= r_mem[i_cmd_task];
            r_rd_live  <= r_live[i_cmd_task];
            r_cur_task <= i_cmd_task;
            r_cur_info <= i_cmd_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_ok) begin
            r_hist[r_hist_ptr] <= {4'(r_cur_task), w_to, w_from, r_cur_info.time_now[31:0]};
        end
    end

    // Legality check and update of the task entry, the global counters and the history pointer.
    always_comb begin
        w_cur  = r_rd_live ? r_rd_rec : '0;
        w_from = w_cur.state;
        w_to   = r_cur_info.target;
        w_len  = r_cur_info.time_now - w_cur.run_start;

        priority if (r_cur_info.range_err) begin
            w_status = tstt_pkg::STAT_RANGE;
        end else if (!tstt_pkg::LEGAL_TARGETS[w_from][w_to]) begin
            w_status = tstt_pkg::STAT_ILLEGAL;
        end else begin
            w_status = tstt_pkg::STAT_OK;
        end
        w_ok = (w_status == tstt_pkg::STAT_OK);

        n_rec = w_cur;
        if (w_ok) begin
            n_rec.last_state = w_from;
            n_rec.state      = w_to;
            if (w_from == tstt_pkg::TS_RUNNING) begin
                n_rec.last_len  = w_len;
                n_rec.run_total = w_cur.run_total + w_len;
            end
            if (w_to == tstt_pkg::TS_RUNNING) begin
                n_rec.run_start = r_cur_info.time_now;
                n_rec.switches  = w_cur.switches + 32'd1;
            end
            if (w_from == tstt_pkg::TS_BLOCKED && w_to == tstt_pkg::TS_READY) begin
                n_rec.wake_lat = w_len[31:0];
            end
        end

        n_trans_cnt = w_ok ? r_trans_cnt + 32'd1 : r_trans_cnt;
        n_rej_cnt   = (w_status == tstt_pkg::STAT_ILLEGAL) ? r_rej_cnt + 32'd1 : r_rej_cnt;
        if (!w_ok) begin
            n_hist_ptr = r_hist_ptr;
        end else if (r_hist_ptr == HW'(HISTORY_DEPTH - 1)) begin
            n_hist_ptr = '0;
        end else begin
            n_hist_ptr = r_hist_ptr + HW'(1);
        end
        w_slot_ext = HXW'(r_hist_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_trans_cnt <= '0;
            r_rej_cnt   <= '0;
            r_hist_ptr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_trans_cnt <= n_trans_cnt;
                r_rej_cnt   <= n_rej_cnt;
                r_hist_ptr  <= n_hist_ptr;
                if (w_ok) begin
                    r_live[r_cur_task] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status  <= w_status;
            r_out_prior   <= w_from;
            r_out_changed <= w_ok;
            r_out_rec     <= n_rec;
            r_out_slot    <= w_ok ? w_slot_ext[2:0] : 3'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_prior_state       = r_out_prior;
    assign o_state_changed     = r_out_changed;
    assign o_ended_run_length  = r_out_rec.last_len;
    assign o_task_run_total    = r_out_rec.run_total;
    assign o_task_switches     = r_out_rec.switches;
    assign o_task_wake_latency = r_out_rec.wake_lat;
    assign o_transitions_total = r_trans_cnt;
    assign o_rejected_total    = r_rej_cnt;
    assign o_history_slot      = r_out_slot;

endmodule
`default_nettype wire

/* test/tstt_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task state transition tracker result checker
// Watches the request and result channels, keeps its own copy of the task
// table to predict every result, and compares the results field by field.
// ----------------------------------------------------------------------------
module tstt_result_checker
    import tstt_pkg::*;
#(
    parameter int NUM_TASKS     = 16,
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_task_number,
    input  logic [2:0]  i_target_state,
    input  logic [63:0] i_time_now,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [2:0]  i_prior_state,
    input  logic        i_state_changed,
    input  logic [63:0] i_ended_run_length,
    input  logic [63:0] i_task_run_total,
    input  logic [31:0] i_task_switches,
    input  logic [31:0] i_task_wake_latency,
    input  logic [31:0] i_transitions_total,
    input  logic [31:0] i_rejected_total,
    input  logic [2:0]  i_history_slot,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_compared,
    output int          o_changes
);

    typedef struct packed {
        t_status     status;
        logic [2:0]  prior;
        logic        changed;
        logic [63:0] ended_len;
        logic [63:0] run_total;
        logic [31:0] switches;
        logic [31:0] wake;
        logic [31:0] moves;
        logic [31:0] rejects;
        logic [2:0]  slot;
    } t_report;

    // Shadow of the per-task table and the global counters.
    logic [2:0]  tbl_state     [NUM_TASKS];
    logic [63:0] tbl_run_start [NUM_TASKS];
    logic [63:0] tbl_last_len  [NUM_TASKS];
    logic [63:0] tbl_run_total [NUM_TASKS];
    logic [31:0] tbl_switches  [NUM_TASKS];
    logic [31:0] tbl_wake      [NUM_TASKS];
    logic [31:0] move_count;
    logic [31:0] reject_count;
    logic [2:0]  ring_ptr;

    t_report     awaited_reports [$];
    t_report     oldest;
    int          mismatches;
    int          compared;
    int          changes;

    function automatic logic move_allowed(input logic [2:0] src, input logic [2:0] dst);
        case (src)
            TS_INVALID:   return dst inside {TS_READY, TS_DORMANT};
            TS_READY:     return dst inside {TS_RUNNING, TS_BLOCKED, TS_SUSPENDED,
                                             TS_TERMINATED};
            TS_RUNNING:   return dst inside {TS_READY, TS_BLOCKED, TS_SUSPENDED,
                                             TS_TERMINATED};
            TS_BLOCKED:   return dst inside {TS_READY, TS_SUSPENDED, TS_TERMINATED};
            TS_SUSPENDED,
            TS_DORMANT:   return dst inside {TS_READY, TS_TERMINATED};
            default:      return 1'b0;
        endcase
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic t_report predict_request(input logic [3:0] num,
                                                input logic [2:0] dst,
                                                input logic [63:0] stamp);
        t_report    r;
        int         idx;
        logic [2:0] src;
        idx = int'(num) % NUM_TASKS;
        src = tbl_state[idx];
        r = '0;
        r.status = STAT_OK;
        r.prior = src;
        if (dst > TS_MAX) begin
            r.status = STAT_RANGE;
        end else if (!move_allowed(src, dst)) begin
            r.status = STAT_ILLEGAL;
            reject_count = reject_count + 32'd1;
        end else begin
            r.changed = 1'b1;
            tbl_state[idx] = dst;
            if (src == TS_RUNNING) begin
                tbl_last_len[idx] = stamp - tbl_run_start[idx];
                tbl_run_total[idx] = tbl_run_total[idx] + tbl_last_len[idx];
            end
            if (dst == TS_RUNNING) begin
                tbl_run_start[idx] = stamp;
                tbl_switches[idx] = tbl_switches[idx] + 32'd1;
            end
            // Wake latency counts from the last time the task started running.
            if (src == TS_BLOCKED && dst == TS_READY) begin
                tbl_wake[idx] = 32'(stamp - tbl_run_start[idx]);
            end
            r.slot = ring_ptr;
            ring_ptr = 3'((int'(ring_ptr) + 1) % HISTORY_DEPTH);
            move_count = move_count + 32'd1;
        end
        r.ended_len = tbl_last_len[idx];
        r.run_total = tbl_run_total[idx];
        r.switches = tbl_switches[idx];
        r.wake = tbl_wake[idx];
        r.moves = move_count;
        r.rejects = reject_count;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_report(input t_report want);
        check_field("status", 64'(want.status), 64'(i_status));
        check_field("prior_state", 64'(want.prior), 64'(i_prior_state));
        check_field("state_changed", 64'(want.changed), 64'(i_state_changed));
        check_field("ended_run_length", want.ended_len, i_ended_run_length);
        check_field("task_run_total", want.run_total, i_task_run_total);
        check_field("task_switches", 64'(want.switches), 64'(i_task_switches));
        check_field("task_wake_latency", 64'(want.wake), 64'(i_task_wake_latency));
        check_field("transitions_total", 64'(want.moves), 64'(i_transitions_total));
        check_field("rejected_total", 64'(want.rejects), 64'(i_rejected_total));
        check_field("history_slot", 64'(want.slot), 64'(i_history_slot));
    endtask

    // The counters are two-state and start at zero.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                tbl_state[k] = TS_INVALID;
                tbl_run_start[k] = '0;
                tbl_last_len[k] = '0;
                tbl_run_total[k] = '0;
                tbl_switches[k] = '0;
                tbl_wake[k] = '0;
            end
            move_count = '0;
            reject_count = '0;
            ring_ptr = '0;
            awaited_reports.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_reports.push_back(predict_request(i_task_number, i_target_state,
                                                          i_time_now));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("result transaction arrived with no request outstanding");
                    mismatches++;
                end else begin
                    oldest = awaited_reports.pop_front();
                    compare_report(oldest);
                    compared++;
                    if (oldest.changed) begin
                        changes++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_outstanding <= awaited_reports.size();
        o_compared <= compared;
        o_changes <= changes;
    end

endmodule

/* test/tb_task_state_transition_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task state transition tracker testbench
// Drives scheduler requests into the tracker with bursty timing against a
// stalling consumer; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_task_state_transition_tracker;
    import tstt_pkg::*;

    localparam int RANDOM_REQUESTS = 530;
    // Cycles without any transaction on either channel before giving up.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Extra wait at the end after the last result has come back.
    localparam int SETTLE_CYCLES   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_task_number = '0;
    logic [2:0]  i_target_state = '0;
    logic [63:0] i_time_now = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_prior_state;
    logic        o_state_changed;
    logic [63:0] o_ended_run_length;
    logic [63:0] o_task_run_total;
    logic [31:0] o_task_switches;
    logic [31:0] o_task_wake_latency;
    logic [31:0] o_transitions_total;
    logic [31:0] o_rejected_total;
    logic [2:0]  o_history_slot;

    int          fail_count;
    int          outstanding;
    int          compared;
    int          changes;

    // Stimulus-side view of where each task should be, used only to steer the
    // random requests toward legal moves so the run reaches deep states.
    logic [2:0]  planned_state [16];
    logic [63:0] system_clock;
    int          requests_sent;
    int          burst_left;
    // Mirrors the value last scheduled onto i_in_valid.
    logic        valid_held;

    // Receiver stall pattern state; two-state, so both start at zero.
    int          stall_mode;
    int          stall_left;

    // Watchdog state.
    int          quiet_cycles;

    always #4 i_clk = ~i_clk;

    task_state_transition_tracker dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_task_number       (i_task_number),
        .i_target_state      (i_target_state),
        .i_time_now          (i_time_now),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_prior_state       (o_prior_state),
        .o_state_changed     (o_state_changed),
        .o_ended_run_length  (o_ended_run_length),
        .o_task_run_total    (o_task_run_total),
        .o_task_switches     (o_task_switches),
        .o_task_wake_latency (o_task_wake_latency),
        .o_transitions_total (o_transitions_total),
        .o_rejected_total    (o_rejected_total),
        .o_history_slot      (o_history_slot)
    );

    tstt_result_checker result_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_task_number       (i_task_number),
        .i_target_state      (i_target_state),
        .i_time_now          (i_time_now),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_status            (o_status),
        .i_prior_state       (o_prior_state),
        .i_state_changed     (o_state_changed),
        .i_ended_run_length  (o_ended_run_length),
        .i_task_run_total    (o_task_run_total),
        .i_task_switches     (o_task_switches),
        .i_task_wake_latency (o_task_wake_latency),
        .i_transitions_total (o_transitions_total),
        .i_rejected_total    (o_rejected_total),
        .i_history_slot      (o_history_slot),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding),
        .o_compared          (compared),
        .o_changes           (changes)
    );

    // The consumer switches at random between three behaviors:
    // never stalling, stalling about a third of the time, and stalling almost
    // always so that the internal queue fills and backpressure reaches the
    // request side.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // The watchdog restarts on every transaction on either channel. If the
    // design hangs, the run ends here instead of spinning forever.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request and holds it until the tracker takes it. The valid
    // line stays high straight into the next request unless the current burst
    // has ended, in which case the sender may go quiet for a random gap.
    task automatic issue(input logic [3:0] num, input logic [2:0] dst,
                         input logic [63:0] stamp);
        logic [7:0] exits;
        int         gap;
        exits = LEGAL_TARGETS[planned_state[num]];
        if (exits[dst]) begin
            planned_state[num] = dst;
        end
        i_in_valid <= 1'b1;
        valid_held = 1'b1;
        i_task_number <= num;
        i_target_state <= dst;
        i_time_now <= stamp;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops sending and waits for every outstanding result to come back.
    task automatic drain_results();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        do begin
            @(posedge i_clk);
        end while (outstanding != 0);
    endtask

    // Most requests follow the legal state graph of the chosen task, with a
    // slowly advancing system time so the run lengths stay readable. The rest
    // are noise: any target code, including the same state, illegal moves and
    // the out-of-range code. Occasionally the time jumps to a random 64-bit
    // value so that run lengths and totals wrap.
    task automatic random_request();
        logic [3:0]  num;
        logic [2:0]  dst;
        logic [63:0] stamp;
        logic [7:0]  exits;
        num = 4'($urandom_range(0, 15));
        exits = LEGAL_TARGETS[planned_state[num]];
        if ($urandom_range(0, 39) == 0) begin
            system_clock = {$urandom(), $urandom()};
        end else begin
            system_clock = system_clock + 64'($urandom_range(1, 500));
        end
        stamp = system_clock;
        if ($urandom_range(0, 99) < 85 && exits != 8'h00) begin
            // Termination is a dead end, so it is picked only rarely.
            do begin
                dst = 3'($urandom_range(0, 6));
            end while (!exits[dst] ||
                       (dst == TS_TERMINATED && $urandom_range(0, 19) != 0));
        end else begin
            dst = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) begin
                stamp = {$urandom(), $urandom()};
            end
        end
        issue(num, dst, stamp);
    endtask

    initial begin
        for (int k = 0; k < 16; k++) begin
            planned_state[k] = TS_INVALID;
        end
        system_clock = 64'd1000;
        requests_sent = 0;
        burst_left = $urandom_range(1, 12);
        valid_held = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Task 0 walks through the main paths: out-of-range
        // target while invalid, same-state and illegal requests, a run ending
        // in blocked, the wake from blocked, a run that starts at the top of
        // the time range and ends after the counter wrapped, and finally
        // termination, after which no exit is allowed.
        issue(4'd0, 3'd7, 64'd0);
        issue(4'd0, TS_INVALID, 64'd1);
        issue(4'd0, TS_RUNNING, 64'd2);
        issue(4'd0, TS_READY, 64'd10);
        issue(4'd0, TS_RUNNING, 64'd100);
        issue(4'd0, TS_RUNNING, 64'd120);
        issue(4'd0, TS_BLOCKED, 64'd350);
        issue(4'd0, TS_READY, 64'd400);
        issue(4'd0, TS_RUNNING, '1);
        issue(4'd0, TS_SUSPENDED, 64'd5);
        issue(4'd0, TS_READY, 64'd6);
        issue(4'd0, TS_TERMINATED, 64'd7);
        issue(4'd0, TS_READY, 64'd8);
        issue(4'd0, 3'd7, '1);
        // The highest task number goes through dormant, blocked and suspended.
        issue(4'd15, TS_DORMANT, 64'd20);
        issue(4'd15, TS_READY, 64'd21);
        issue(4'd15, TS_BLOCKED, 64'd22);
        issue(4'd15, TS_SUSPENDED, 64'd23);
        issue(4'd15, TS_TERMINATED, 64'd24);
        // Large times with the top bit set; running back to ready, then exit.
        issue(4'd9, TS_READY, 64'h8000_0000_0000_0000);
        issue(4'd9, TS_RUNNING, 64'h8000_0000_0000_0010);
        issue(4'd9, TS_READY, 64'h8000_0001_2345_6789);
        issue(4'd9, TS_TERMINATED, 64'h8000_0001_2345_678A);
        // Dormant straight to terminated.
        issue(4'd5, TS_DORMANT, 64'd30);
        issue(4'd5, TS_TERMINATED, 64'd31);

        // Let the pipeline run completely dry once before the random part.
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            random_request();
            if (n == RANDOM_REQUESTS / 2) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests on 16 tasks with every target code, %0d results compared",
                 requests_sent, compared);
        $display("  %0d accepted state changes; the rest rejected or out of range", changes);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tstt_pkg.sv
rtl/tstt_front.sv
rtl/tstt_back.sv
rtl/task_state_transition_tracker.sv
test/tstt_result_checker.sv
test/tb_task_state_transition_tracker.sv
